// File: rtl/ray_triangle_intersect_assert.svh
// Assertion macros for the ray/triangle intersector.
// Used by the top level only; expects signals named clk and rst_n in scope.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rti: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rti: next-cycle check failed");

`endif

// File: rtl/rti_pkg.sv
// Shared types, widths and codes for the ray/triangle intersector.
// No dependencies; imported by every rti module.
`default_nettype none

package rti_pkg;

    localparam int FRAC     = 16;                 // fraction bits of coordinates
    localparam int CRD_W    = 32;                 // coordinate width
    localparam int EDGE_W   = CRD_W + 1;          // edge / origin offset
    localparam int PROD_W   = 2 * EDGE_W;         // edge by edge product
    localparam int CROSS_W  = PROD_W + 1;         // cross product component
    localparam int SPLIT_W  = EDGE_W;             // low unsigned slice of a wide operand
    localparam int HALF_W   = CROSS_W - SPLIT_W;  // signed high slice
    localparam int PP_W     = EDGE_W + HALF_W;    // partial product
    localparam int DOT_W    = CROSS_W + EDGE_W + 2;
    localparam int NUM_W    = DOT_W + FRAC + 1;   // t numerator after shift
    localparam int QUO_W    = 63;                 // quotient bits below the saturation point
    localparam int REM_W    = DOT_W;
    localparam int EPS_W    = 16;
    localparam int EA_LO    = DOT_W / 2;
    localparam int EA_HI    = DOT_W - EA_LO;
    localparam int TV_LO    = 32;
    localparam int TV_HI    = QUO_W - TV_LO;
    localparam int PT_W     = CRD_W + QUO_W + 1;

    localparam int NDOT  = 5;
    localparam int DOT_A = 0;   // e1 . h   (determinant)
    localparam int DOT_U = 1;   // s  . h
    localparam int DOT_V = 2;   // d  . q
    localparam int DOT_T = 3;   // e2 . q
    localparam int DOT_N = 4;   // d  . normal

    localparam logic       ACT_LOAD  = 1'b0;
    localparam logic       ACT_RAY   = 1'b1;
    localparam logic [1:0] CORNER_0  = 2'd0;
    localparam logic [1:0] CORNER_1  = 2'd1;
    localparam logic [1:0] CORNER_2  = 2'd2;
    localparam logic [1:0] CORNER_NONE = 2'd3;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    typedef logic signed [CRD_W-1:0]   crd_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [PP_W-1:0]    pp_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic [REM_W-1:0]          rem_t;

    localparam crd_t CRD_MAX = crd_t'({1'b0, {(CRD_W-1){1'b1}}});
    localparam crd_t CRD_MIN = crd_t'({1'b1, {(CRD_W-1){1'b0}}});

    typedef struct {
        logic valid;
        crd_t d [3];
        crd_t o [3];
        dot_t a;
        dot_t un;
        dot_t vn;
        dot_t tn;
        dot_t dn;
    } geom_out_t;

    typedef struct {
        logic             valid;
        logic             hit;
        logic             sat;
        logic [NUM_W-2:0] num;
        logic [DOT_W-2:0] den;
        crd_t             d [3];
        crd_t             o [3];
    } test_out_t;

    typedef struct {
        logic             valid;
        logic             hit;
        logic [QUO_W-1:0] tv;
        crd_t             d [3];
        crd_t             o [3];
    } div_out_t;

    typedef struct {
        logic valid;
        logic hit;
        crd_t p [3];
    } pt_out_t;

    function automatic edge_t ext_edge(crd_t v);
        return $signed({v[CRD_W-1], v});
    endfunction

endpackage

`default_nettype wire

// File: rtl/rti_geom.sv
// Corner store and geometry front end: edges, cross products, five dot products.
// Depends on rti_pkg. Six register stages.
`default_nettype none

module rti_geom
    import rti_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       ray_in,
    input  logic       load_in,
    input  logic [1:0] corner_in,
    input  crd_t       pos_in [3],
    input  crd_t       dir_in [3],
    output geom_out_t  geom_out
);

    crd_t   corner_reg [3][3];
    edge_t  e1_c [3];
    edge_t  e2_c [3];
    edge_t  s_c [3];

    logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    crd_t   d1_reg [3], d2_reg [3], d3_reg [3], d4_reg [3], d5_reg [3], d6_reg [3];
    crd_t   o1_reg [3], o2_reg [3], o3_reg [3], o4_reg [3], o5_reg [3], o6_reg [3];
    edge_t  s1_reg [3], s2_reg [3], s3_reg [3];
    edge_t  e11_reg [3], e12_reg [3], e13_reg [3];
    edge_t  e21_reg [3], e22_reg [3], e23_reg [3];
    prod_t  pna_reg [3], pnb_reg [3], pha_reg [3], phb_reg [3], pqa_reg [3], pqb_reg [3];
    cross_t cn_c [3], ch_c [3], cq_c [3];
    cross_t nrm_reg [3], h_reg [3], q_reg [3];
    edge_t  nar_c [NDOT][3];
    cross_t wid_c [NDOT][3];
    pp_t    pph_reg [NDOT][3];
    pp_t    ppl_reg [NDOT][3];
    dot_t   term_reg [NDOT][3];
    dot_t   dot_reg [NDOT];

    // corner store, written straight from an accepted load item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    corner_reg[c][i] <= '0;
                end
            end
        end
        else if (load_in)
        begin
            case (corner_in)
                CORNER_0: corner_reg[0] <= pos_in;
                CORNER_1: corner_reg[1] <= pos_in;
                CORNER_2: corner_reg[2] <= pos_in;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_c[i] = ext_edge(corner_reg[1][i]) - ext_edge(corner_reg[0][i]);
            e2_c[i] = ext_edge(corner_reg[2][i]) - ext_edge(corner_reg[0][i]);
            s_c[i]  = ext_edge(pos_in[i]) - ext_edge(corner_reg[0][i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= ray_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // carried operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg  <= dir_in;  o1_reg  <= pos_in;
            s1_reg  <= s_c;     e11_reg <= e1_c;    e21_reg <= e2_c;
            d2_reg  <= d1_reg;  o2_reg  <= o1_reg;
            s2_reg  <= s1_reg;  e12_reg <= e11_reg; e22_reg <= e21_reg;
            d3_reg  <= d2_reg;  o3_reg  <= o2_reg;
            s3_reg  <= s2_reg;  e13_reg <= e12_reg; e23_reg <= e22_reg;
            d4_reg  <= d3_reg;  o4_reg  <= o3_reg;
            d5_reg  <= d4_reg;  o5_reg  <= o4_reg;
            d6_reg  <= d5_reg;  o6_reg  <= o5_reg;
        end
    end

    // stage 2: cross product terms; stage 3: differences
    for (genvar i = 0; i < 3; i++)
    begin : g_cross
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pna_reg[i] <= PROD_W'(e11_reg[I1]) * PROD_W'(e21_reg[I2]);
                pnb_reg[i] <= PROD_W'(e11_reg[I2]) * PROD_W'(e21_reg[I1]);
                pha_reg[i] <= PROD_W'(ext_edge(d1_reg[I1])) * PROD_W'(e21_reg[I2]);
                phb_reg[i] <= PROD_W'(ext_edge(d1_reg[I2])) * PROD_W'(e21_reg[I1]);
                pqa_reg[i] <= PROD_W'(s1_reg[I1]) * PROD_W'(e11_reg[I2]);
                pqb_reg[i] <= PROD_W'(s1_reg[I2]) * PROD_W'(e11_reg[I1]);
            end
        end

        assign cn_c[i] = CROSS_W'(pna_reg[i]) - CROSS_W'(pnb_reg[i]);
        assign ch_c[i] = CROSS_W'(pha_reg[i]) - CROSS_W'(phb_reg[i]);
        assign cq_c[i] = CROSS_W'(pqa_reg[i]) - CROSS_W'(pqb_reg[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nrm_reg[i] <= cn_c[i] >>> FRAC;   // face normal, fits without saturation
                h_reg[i]   <= ch_c[i];
                q_reg[i]   <= cq_c[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nar_c[DOT_A][i] = e13_reg[i];           wid_c[DOT_A][i] = h_reg[i];
            nar_c[DOT_U][i] = s3_reg[i];            wid_c[DOT_U][i] = h_reg[i];
            nar_c[DOT_V][i] = ext_edge(d3_reg[i]);  wid_c[DOT_V][i] = q_reg[i];
            nar_c[DOT_T][i] = e23_reg[i];           wid_c[DOT_T][i] = q_reg[i];
            nar_c[DOT_N][i] = ext_edge(d3_reg[i]);  wid_c[DOT_N][i] = nrm_reg[i];
        end
    end

    // stage 4: split products, stage 5: recombine, stage 6: sum of three
    for (genvar j = 0; j < NDOT; j++)
    begin : g_dot
        for (genvar i = 0; i < 3; i++)
        begin : g_term
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pph_reg[j][i] <= PP_W'(nar_c[j][i])
                                     * PP_W'($signed(wid_c[j][i][CROSS_W-1:SPLIT_W]));
                    ppl_reg[j][i] <= PP_W'(nar_c[j][i])
                                     * PP_W'($signed({1'b0, wid_c[j][i][SPLIT_W-1:0]}));
                    term_reg[j][i] <= (DOT_W'(pph_reg[j][i]) <<< SPLIT_W)
                                      + DOT_W'(ppl_reg[j][i]);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dot_reg[j] <= term_reg[j][0] + term_reg[j][1] + term_reg[j][2];
            end
        end
    end

    always_comb
    begin
        geom_out.valid = v6_reg;
        geom_out.d     = d6_reg;
        geom_out.o     = o6_reg;
        geom_out.a     = dot_reg[DOT_A];
        geom_out.un    = dot_reg[DOT_U];
        geom_out.vn    = dot_reg[DOT_V];
        geom_out.tn    = dot_reg[DOT_T];
        geom_out.dn    = dot_reg[DOT_N];
    end

endmodule

`default_nettype wire

// File: rtl/rti_test.sv
// Culling, determinant, barycentric and distance tests; four register stages.
// Depends on rti_pkg.
`default_nettype none

module rti_test
    import rti_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [EPS_W-1:0] eps,
    input  geom_out_t        geom_in,
    output test_out_t        test_out
);

    localparam int SUV_W = DOT_W + 1;
    localparam int EPL_W = EPS_W + EA_LO;
    localparam int EPH_W = EPS_W + EA_HI;

    logic  v1_reg, v2_reg, v3_reg, v4_reg;
    crd_t  d1_reg [3], d2_reg [3], d3_reg [3], d4_reg [3];
    crd_t  o1_reg [3], o2_reg [3], o3_reg [3], o4_reg [3];
    logic  neg_c;
    dot_t  a1_reg, u1_reg, v1n_reg, t1_reg, a2_reg, a3_reg;
    logic  miss1_reg, miss2_reg, miss3_reg;
    logic  small2_reg, badu2_reg, vneg2_reg, badv3_reg;
    logic  [DOT_W-1:0] lim_c;
    logic  signed [SUV_W-1:0] suv2_reg;
    logic  [EPL_W-1:0] eplo2_reg;
    logic  [EPH_W-1:0] ephi2_reg;
    num_t  tsh2_reg, tsh3_reg;
    logic  [NUM_W-1:0] epsa3_reg;
    logic  tmiss_c, sat_c;
    logic  hit4_reg, sat4_reg;
    logic  [NUM_W-2:0] num4_reg;
    logic  [DOT_W-2:0] den4_reg;

    assign neg_c = geom_in.a[DOT_W-1];
    assign lim_c = DOT_W'(eps) << (2 * FRAC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= geom_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign tmiss_c = tsh3_reg <= $signed(epsa3_reg);
    assign sat_c   = (tsh3_reg >>> QUO_W) >= NUM_W'(a3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // T1: fold the determinant sign into all numerators
            d1_reg    <= geom_in.d;
            o1_reg    <= geom_in.o;
            a1_reg    <= neg_c ? -geom_in.a  : geom_in.a;
            u1_reg    <= neg_c ? -geom_in.un : geom_in.un;
            v1n_reg   <= neg_c ? -geom_in.vn : geom_in.vn;
            t1_reg    <= neg_c ? -geom_in.tn : geom_in.tn;
            miss1_reg <= (!geom_in.dn[DOT_W-1] && geom_in.dn != '0) || geom_in.a == '0;

            // T2
            d2_reg     <= d1_reg;
            o2_reg     <= o1_reg;
            a2_reg     <= a1_reg;
            miss2_reg  <= miss1_reg;
            small2_reg <= $unsigned(a1_reg) < lim_c;
            badu2_reg  <= u1_reg[DOT_W-1] || (u1_reg > a1_reg);
            vneg2_reg  <= v1n_reg[DOT_W-1];
            suv2_reg   <= SUV_W'(u1_reg) + SUV_W'(v1n_reg);
            eplo2_reg  <= EPL_W'(eps) * EPL_W'(a1_reg[EA_LO-1:0]);
            ephi2_reg  <= EPH_W'(eps) * EPH_W'(a1_reg[DOT_W-1:EA_LO]);
            tsh2_reg   <= NUM_W'(t1_reg) <<< FRAC;

            // T3
            d3_reg    <= d2_reg;
            o3_reg    <= o2_reg;
            a3_reg    <= a2_reg;
            tsh3_reg  <= tsh2_reg;
            miss3_reg <= miss2_reg || small2_reg || badu2_reg;
            badv3_reg <= vneg2_reg || (suv2_reg > SUV_W'(a2_reg));
            epsa3_reg <= (NUM_W'(ephi2_reg) << EA_LO) + NUM_W'(eplo2_reg);

            // T4
            d4_reg   <= d3_reg;
            o4_reg   <= o3_reg;
            hit4_reg <= !(miss3_reg || badv3_reg || tmiss_c);
            sat4_reg <= sat_c;
            num4_reg <= tsh3_reg[NUM_W-2:0];
            den4_reg <= a3_reg[DOT_W-2:0];
        end
    end

    always_comb
    begin
        test_out.valid = v4_reg;
        test_out.hit   = hit4_reg;
        test_out.sat   = sat4_reg;
        test_out.num   = num4_reg;
        test_out.den   = den4_reg;
        test_out.d     = d4_reg;
        test_out.o     = o4_reg;
    end

endmodule

`default_nettype wire

// File: rtl/rti_div.sv
// Pipelined restoring divider for the hit distance, one quotient bit per stage.
// Depends on rti_pkg.
`default_nettype none

module rti_div
    import rti_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  test_out_t div_in,
    output div_out_t  div_out
);

    logic             v_reg   [QUO_W];
    logic             hit_reg [QUO_W];
    logic             sat_reg [QUO_W];
    rem_t             rem_reg [QUO_W];
    logic [QUO_W-1:0] nlo_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DOT_W-2:0] den_reg [QUO_W];
    crd_t             d_reg   [QUO_W][3];
    crd_t             o_reg   [QUO_W][3];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic             pv, ph, ps, ge;
        rem_t             pr, sh;
        logic [QUO_W-1:0] pn, pq;
        logic [DOT_W-2:0] pden;
        crd_t             pd [3];
        crd_t             po [3];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                pv   = div_in.valid;
                ph   = div_in.hit;
                ps   = div_in.sat;
                pr   = REM_W'(div_in.num >> QUO_W);
                pn   = div_in.num[QUO_W-1:0];
                pq   = '0;
                pden = div_in.den;
                pd   = div_in.d;
                po   = div_in.o;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                pv   = v_reg[k-1];
                ph   = hit_reg[k-1];
                ps   = sat_reg[k-1];
                pr   = rem_reg[k-1];
                pn   = nlo_reg[k-1];
                pq   = quo_reg[k-1];
                pden = den_reg[k-1];
                pd   = d_reg[k-1];
                po   = o_reg[k-1];
            end
        end

        assign sh = {pr[REM_W-2:0], pn[QUO_W-1]};
        assign ge = sh >= REM_W'(pden);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hit_reg[k] <= ph;
                sat_reg[k] <= ps;
                rem_reg[k] <= ge ? sh - REM_W'(pden) : sh;
                nlo_reg[k] <= pn << 1;
                quo_reg[k] <= {pq[QUO_W-2:0], ge};
                den_reg[k] <= pden;
                d_reg[k]   <= pd;
                o_reg[k]   <= po;
            end
        end
    end

    always_comb
    begin
        div_out.valid = v_reg[QUO_W-1];
        div_out.hit   = hit_reg[QUO_W-1];
        div_out.tv    = sat_reg[QUO_W-1] ? {QUO_W{1'b1}} : quo_reg[QUO_W-1];
        div_out.d     = d_reg[QUO_W-1];
        div_out.o     = o_reg[QUO_W-1];
    end

endmodule

`default_nettype wire

// File: rtl/rti_point.sv
// Hit point: origin + (dir * t >> FRAC), saturated to 32 bits, zero on a miss; three stages.
// Depends on rti_pkg.
`default_nettype none

module rti_point
    import rti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  div_out_t pt_in,
    output pt_out_t  pt_out
);

    localparam int PLO_W = CRD_W + TV_LO + 1;
    localparam int PHI_W = CRD_W + TV_HI + 1;

    logic  v1_reg, v2_reg, v3_reg;
    logic  h1_reg, h2_reg, h3_reg;
    crd_t  o1_reg [3], o2_reg [3];
    logic signed [PLO_W-1:0] plo_reg [3];
    logic signed [PHI_W-1:0] phi_reg [3];
    logic signed [PT_W-1:0]  prod_c [3];
    logic signed [PT_W-1:0]  sh_reg [3];
    logic signed [PT_W:0]    sum_c [3];
    crd_t  p_next [3];
    crd_t  p3_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_c[i] = (PT_W'(phi_reg[i]) <<< TV_LO) + PT_W'(plo_reg[i]);
            sum_c[i]  = (PT_W + 1)'(o2_reg[i]) + (PT_W + 1)'(sh_reg[i]);
            if (!h2_reg)
            begin
                p_next[i] = '0;
            end
            else if ((&sum_c[i][PT_W:CRD_W-1]) || !(|sum_c[i][PT_W:CRD_W-1]))
            begin
                p_next[i] = sum_c[i][CRD_W-1:0];
            end
            else
            begin
                p_next[i] = sum_c[i][PT_W] ? CRD_MIN : CRD_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pt_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg <= pt_in.hit;
            o1_reg <= pt_in.o;
            for (int i = 0; i < 3; i++)
            begin
                plo_reg[i] <= PLO_W'(pt_in.d[i]) * PLO_W'($signed({1'b0, pt_in.tv[TV_LO-1:0]}));
                phi_reg[i] <= PHI_W'(pt_in.d[i])
                              * PHI_W'($signed({1'b0, pt_in.tv[QUO_W-1:TV_LO]}));
                sh_reg[i]  <= prod_c[i] >>> FRAC;
            end
            h2_reg <= h1_reg;
            o2_reg <= o1_reg;
            h3_reg <= h2_reg;
            p3_reg <= p_next;
        end
    end

    always_comb
    begin
        pt_out.valid = v3_reg;
        pt_out.hit   = h3_reg;
        pt_out.p     = p3_reg;
    end

endmodule

`default_nettype wire

// File: rtl/ray_triangle_intersect.sv
// Back-face culled ray/triangle intersector, fixed point, fully pipelined.
// Depends on rti_pkg, rti_geom, rti_test, rti_div, rti_point and the assert header.
//
// Usage:
//   Input stream s_*: tuser[0] = action (0 load corner, 1 cast ray),
//   tuser[2:1] = corner. tdata = pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
//   32 bits each, Q16.16, pos_x in the lowest bits.
//   A load item writes one corner at once; it yields no result. Corner 3 is
//   dropped. A ray item sees the triangle as loaded before it.
//   Output stream m_*: one item per ray. tuser[0] = hit, tdata = hit_x,
//   hit_y, hit_z (zero on a miss).
//   cfg_wen/cfg_wdata write epsilon (reset 1); write it only while idle.
//   Throughput: one item per cycle while the skid entry is free. A ray result
//   passes rti_geom, rti_test, rti_div, rti_point and the output register; the
//   63-stage restoring divider for the hit distance makes up most of that path.
//   Reset clears the corners (triangle at the origin) and the pipeline.
//   Stall: the output register plus a one-entry skid buffer; while the skid
//   entry is occupied the pipeline holds and s_tready is low.
`default_nettype none

`include "ray_triangle_intersect_assert.svh"

module ray_triangle_intersect
    import rti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [EPS_W-1:0]     cfg_wdata,   // epsilon
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [6*CRD_W-1:0]   s_tdata,     // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
    input  logic [2:0]           s_tuser,     // action, corner[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [3*CRD_W-1:0]   m_tdata,     // hit_x, hit_y, hit_z
    output logic [0:0]           m_tuser      // hit
);

    logic [EPS_W-1:0] eps_reg;

    logic      en;
    logic      accept;
    logic      ray_acc;
    logic      load_acc;
    crd_t      pos_c [3];
    crd_t      dir_c [3];

    geom_out_t geom_out;
    test_out_t test_out;
    div_out_t  div_out;
    pt_out_t   pt_out;

    logic      out_v_reg;
    logic      out_hit_reg;
    crd_t      out_p_reg [3];
    logic      skid_v_reg;
    logic      skid_hit_reg;
    crd_t      skid_p_reg [3];
    logic      out_free;
    logic      out_load;
    logic      skid_load;
    logic      out_v_next;
    logic      skid_v_next;

    // epsilon register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_wen)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    // pipeline advances whenever the skid entry is free
    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;
    assign ray_acc  = accept && (s_tuser[0] == ACT_RAY);
    assign load_acc = accept && (s_tuser[0] == ACT_LOAD) && (s_tuser[2:1] != CORNER_NONE);

    for (genvar i = 0; i < 3; i++)
    begin : g_unpack
        assign pos_c[i] = s_tdata[i*CRD_W +: CRD_W];
        assign dir_c[i] = s_tdata[(3+i)*CRD_W +: CRD_W];
    end

    rti_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ray_in    (ray_acc),
        .load_in   (load_acc),
        .corner_in (s_tuser[2:1]),
        .pos_in    (pos_c),
        .dir_in    (dir_c),
        .geom_out  (geom_out)
    );

    rti_test u_test (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .eps      (eps_reg),
        .geom_in  (geom_out),
        .test_out (test_out)
    );

    rti_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .div_in  (test_out),
        .div_out (div_out)
    );

    rti_point u_point (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .pt_in  (div_out),
        .pt_out (pt_out)
    );

    // output register + skid entry
    always_comb
    begin
        out_free    = !out_v_reg || m_tready;
        out_load    = out_free && (skid_v_reg || pt_out.valid);
        skid_load   = !skid_v_reg && pt_out.valid && !out_free;
        out_v_next  = out_load ? 1'b1 : (m_tready ? 1'b0 : out_v_reg);
        skid_v_next = skid_load ? 1'b1 : (out_free ? 1'b0 : skid_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg <= skid_v_reg ? skid_hit_reg : pt_out.hit;
            out_p_reg   <= skid_v_reg ? skid_p_reg   : pt_out.p;
        end
        if (skid_load)
        begin
            skid_hit_reg <= pt_out.hit;
            skid_p_reg   <= pt_out.p;
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tuser[0] = out_hit_reg;
    assign m_tdata    = {out_p_reg[2], out_p_reg[1], out_p_reg[0]};

    // a held skid entry always has a result in front of it
    `RTI_ASSERT_SAME(a_skid_behind_out, skid_v_reg, out_v_reg)
    // a miss result carries a zero hit point
    `RTI_ASSERT_SAME(a_miss_zero, out_v_reg && !out_hit_reg, m_tdata == '0)
    // a result arriving into a stalled output is parked, not lost
    `RTI_ASSERT_NEXT(a_stall_parks, out_v_reg && !m_tready && !skid_v_reg && pt_out.valid,
                     skid_v_reg)

endmodule

`default_nettype wire
